// ----- hw/rtl/mchm_pkg.sv -----
`timescale 1ns / 1ps
package mchm_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam logic [31:0] TICK_FREQ_RESET = 32'd1000;
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;

  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [1:0] CMD_PROCESS   = 2'd2;
  localparam logic [1:0] CMD_REGISTER  = 2'd3;

  localparam logic [1:0] KIND_REG     = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  localparam logic [1:0] LS_STARTING = 2'd0;
  localparam logic [1:0] LS_ONLINE   = 2'd1;
  localparam logic [1:0] LS_OFFLINE  = 2'd2;

  localparam logic CFG_TICK_FREQ = 1'b0;
  localparam logic CFG_WATCHDOG  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  channel;
    logic [31:0] tmo_msec;
    logic        required;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [2:0]  channel_res;
    logic [1:0]  channel_state;
    logic [31:0] offline_msec;
    logic        went_online;
    logic        went_offline;
    logic        all_required_online;
    logic        watchdog_refresh;
    logic        last;
  } out_item_t;

endpackage

// ----- hw/rtl/mchm_div.sv -----
`timescale 1ns / 1ps
// Restoring divider: 42-bit dividend by 32-bit divisor, one quotient bit per cycle.
module mchm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [41:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [41:0] quo;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, quo[41]};
  // the partial remainder stays below the divisor, so a borrow means no fit
  assign diff = trial - {1'b0, divisor};
  assign quotient = quo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd42;
        quo <= dividend;
        rem <= '0;
      end else if (run) begin
        // shift one dividend bit in, subtract when it fits
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[40:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[40:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/multi_channel_heartbeat_monitor_core.sv -----
`timescale 1ns / 1ps
// Multi-channel heartbeat timeout monitor.
// Command channel: an item (command, channel, tmo_msec, required) is taken
// on a clock edge with start high and busy low. Tick and heartbeat finish at
// the accepting edge, give no result and never raise busy. Register and an
// empty pass leave busy low and show their one result in the next cycle.
// A process pass walks every registered channel: each channel runs a
// restoring division (elapsed * 1000 / tick_freq_hz) on the shared divider,
// skipped when tick_freq_hz is 0; busy stays high for the whole pass, and
// each report follows its channel.
// Each report is shown for one cycle on res with res_valid; the final result
// of an item has last set. The receiver cannot stall; results are never held.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 tick_freq_hz,
// 1 watchdog_enable) and cfg_data; cfg_ready is always high.
// Reset (rst, synchronous) clears the tick counter, the channel count and
// restores tick_freq_hz to 1000 and watchdog_enable to 0. Channel entries are
// written at registration and read only below the channel count.
module multi_channel_heartbeat_monitor_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mchm_pkg::in_item_t  cmd,
  output logic                res_valid,
  output mchm_pkg::out_item_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import mchm_pkg::*;

  localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NW = $clog2(MAX_CHANNELS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EVAL = 2'd3;

  logic [31:0] tick_freq;
  logic        wd_en;
  logic [31:0] now_ticks;
  logic [NW-1:0] channel_count;

  logic [31:0] last_seen [MAX_CHANNELS];
  logic [31:0] tmo_mem   [MAX_CHANNELS];
  logic        hb_seen   [MAX_CHANNELS];
  logic        req_mem   [MAX_CHANNELS];
  logic [1:0]  lstate    [MAX_CHANNELS];

  logic [1:0]    state;
  logic [NW-1:0] idx;
  logic          allreq;
  logic [31:0]   elapsed;
  logic          div_start, div_done;
  logic [31:0]   div_q;
  logic [31:0]   ms;
  logic [CW-1:0] ci;
  logic          fresh, late;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign ci = idx[CW-1:0];

  mchm_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({10'd0, elapsed} * {32'd0, MS_PER_SEC}),
    .divisor(tick_freq), .done(div_done), .quotient(div_q)
  );

  assign div_start = (state == S_DIV) && (tick_freq != '0);
  assign ms = (tick_freq == '0) ? elapsed : div_q;
  assign fresh = hb_seen[ci] && (ms <= tmo_mem[ci]);
  assign late = ms > tmo_mem[ci];

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_freq <= TICK_FREQ_RESET;
      wd_en <= 1'b0;
    end else if (cfg_valid) begin
      // write register by index
      if (cfg_index == CFG_TICK_FREQ) tick_freq <= cfg_data;
      else wd_en <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    out_item_t res_next;
    logic      valid_next;
    if (rst) begin
      state <= S_IDLE;
      now_ticks <= '0;
      channel_count <= '0;
      res_valid <= 1'b0;
      idx <= '0;
      allreq <= 1'b0;
    end else begin
      res_next = '0;
      valid_next = 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.command)
              CMD_TICK: now_ticks <= now_ticks + 32'd1;
              CMD_HEARTBEAT: begin
                // stamp only registered channels
                if ({{NW{1'b0}}, cmd.channel} < {3'd0, channel_count} &&
                    NW'(cmd.channel) < NW'(MAX_CHANNELS)) begin
                  last_seen[cmd.channel[CW-1:0]] <= now_ticks;
                  hb_seen[cmd.channel[CW-1:0]] <= 1'b1;
                end
              end
              CMD_REGISTER: begin
                valid_next = 1'b1;
                res_next.kind = KIND_REG;
                res_next.last = 1'b1;
                if (cmd.tmo_msec == '0) begin
                  res_next.status = STAT_INVALID;
                end else if (channel_count >= NW'(MAX_CHANNELS)) begin
                  res_next.status = STAT_FULL;
                end else begin
                  res_next.status = STAT_OK;
                  res_next.channel_res = 3'(channel_count);
                  last_seen[channel_count[CW-1:0]] <= now_ticks;
                  hb_seen[channel_count[CW-1:0]] <= 1'b0;
                  lstate[channel_count[CW-1:0]] <= LS_STARTING;
                  tmo_mem[channel_count[CW-1:0]] <= cmd.tmo_msec;
                  req_mem[channel_count[CW-1:0]] <= cmd.required;
                  channel_count <= channel_count + NW'(1);
                end
              end
              default: begin
                if (channel_count == '0) begin
                  valid_next = 1'b1;
                  res_next.kind = KIND_SUMMARY;
                  res_next.all_required_online = 1'b1;
                  res_next.watchdog_refresh = wd_en;
                  res_next.last = 1'b1;
                end else begin
                  idx <= '0;
                  allreq <= 1'b1;
                  elapsed <= now_ticks - last_seen[0];
                  state <= S_DIV;
                end
              end
            endcase
          end
        end
        S_DIV: state <= (tick_freq == '0) ? S_EVAL : S_WAIT;
        S_WAIT: if (div_done) state <= S_EVAL;
        S_EVAL: begin
          // update one channel and emit its report
          valid_next = 1'b1;
          res_next.kind = KIND_REPORT;
          res_next.channel_res = 3'(idx);
          res_next.offline_msec = ms;
          res_next.channel_state = lstate[ci];
          if (fresh) begin
            if (lstate[ci] != LS_ONLINE) begin
              lstate[ci] <= LS_ONLINE;
              res_next.channel_state = LS_ONLINE;
              res_next.offline_msec = '0;
              res_next.went_online = 1'b1;
            end
          end else if (late && lstate[ci] != LS_OFFLINE) begin
            lstate[ci] <= LS_OFFLINE;
            res_next.channel_state = LS_OFFLINE;
            res_next.went_offline = 1'b1;
          end
          if (idx + NW'(1) == channel_count) begin
            res_next.all_required_online = allreq &&
                !(req_mem[ci] && !(fresh || lstate[ci] == LS_ONLINE && !late));
            res_next.watchdog_refresh = wd_en;
            res_next.last = 1'b1;
            state <= S_IDLE;
          end else begin
            if (req_mem[ci] && !(fresh || (lstate[ci] == LS_ONLINE && !late)))
              allreq <= 1'b0;
            idx <= idx + NW'(1);
            elapsed <= now_ticks - last_seen[CW'(idx + NW'(1))];
            state <= S_DIV;
          end
        end
        default: state <= S_IDLE;
      endcase
      res_valid <= valid_next;
      res <= res_next;
    end
  end

  // no item accepted mid-pass
  a_busy_no_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> busy) else $error("busy low during division");
  // channel count never exceeds the table
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    channel_count <= NW'(MAX_CHANNELS)) else $error("channel count overflow");
  // a pass ends with a last result
  a_pass_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_EVAL && state == S_IDLE) |-> (res_valid && res.last))
    else $error("pass ended without last");
endmodule
